### rtl/atfp_pkg.sv
// Shared types and constants of the ASCII time frame parser.
package atfp_pkg;

	// Parser phase codes
	localparam logic [1:0] PH_HUNT1 = 2'd0;
	localparam logic [1:0] PH_HUNT2 = 2'd1;
	localparam logic [1:0] PH_DATA  = 2'd2;
	localparam logic [1:0] PH_SUM   = 2'd3;

	// Configuration register indexes
	localparam logic CFG_FIRST_HEADER  = 1'b0;
	localparam logic CFG_SECOND_HEADER = 1'b1;

	// Frame byte constants
	localparam logic [7:0] TYPE_A     = 8'h41;
	localparam logic [7:0] TYPE_G     = 8'h47;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam int unsigned DIGIT_COUNT = 15;
	localparam logic [3:0] LAST_DIGIT = 4'd14;

	// Packed result word width, rounded up to whole bytes
	localparam int unsigned RESULT_BITS = 50;
	localparam int unsigned RESULT_BYTES_BITS = 56;

	// Verdict of the digit checker for one byte
	typedef struct packed {
		logic       ok;
		logic       last;
		logic [3:0] slot;
		logic [3:0] value;
	} digit_chk_t;

	// Result fields, first field in the highest bits
	typedef struct packed {
		logic [6:0]  second_bcd;
		logic [6:0]  minute_bcd;
		logic [5:0]  hour_bcd;
		logic [2:0]  weekday_digit;
		logic [5:0]  day_bcd;
		logic [4:0]  month_bcd;
		logic [15:0] year_bcd;
	} result_t;

	// Upper ASCII limit of each digit slot; slot 15 does not exist
	function automatic logic [7:0] digit_limit(input logic [3:0] slot);
		logic [7:0] lim;
		case (slot)
			4'd4:    lim = 8'h31;
			4'd6:    lim = 8'h33;
			4'd8:    lim = 8'h36;
			4'd9:    lim = 8'h32;
			4'd11:   lim = 8'h35;
			4'd13:   lim = 8'h35;
			4'd15:   lim = 8'h00;
			default: lim = 8'h39;
		endcase
		return lim;
	endfunction

endpackage

### rtl/ascii_time_frame_parser.sv
// Top level of the ASCII time frame parser: frame state, digit store, result register.
//
// Usage: received bytes enter on the s_ channel, one word per byte. The block
// hunts for the two header bytes set through the cfg_ port, then checks a type
// byte ('A' or 'G') and fifteen ASCII digits against per-position limits while
// keeping an 8-bit wrapping sum from the first header on. When the trailing byte
// matches the sum, one result word with the time in packed BCD appears on the
// m_ channel; a bad byte or a wrong sum drops the frame silently.
// Throughput: one byte per cycle unless stalled; each is parsed in the cycle taken.
// Latency: the result is valid in the cycle after the checksum byte is taken,
// held in a single output register.
// Stall: while a result waits in the output register, bytes are still taken,
// except a checksum byte, which is held off until the result is taken.
// Reset (arst_n low): returns to the hunt for the first header, clears both
// header registers and the output valid. The digit store has no reset.
// Configuration writes are meant for idle periods only.
module ascii_time_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	// s_tdata fields, low bit up: rx_byte[7:0]
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,
	// m_tdata fields, low bit up: year_bcd[15:0], month_bcd[4:0], day_bcd[5:0],
	// weekday_digit[2:0], hour_bcd[5:0], minute_bcd[6:0], second_bcd[6:0], zero fill
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [7:0]  cfg_data
);

	logic [7:0]           first_hdr_q;
	logic [7:0]           second_hdr_q;
	logic [1:0]           phase_q;
	logic [3:0]           field_pos_q;
	logic [7:0]           sum_q;
	logic [3:0]           digit_q [atfp_pkg::DIGIT_COUNT];
	logic                 out_valid_q;
	atfp_pkg::result_t    out_data_q;

	logic                 accept;
	logic [7:0]           rx_byte;
	logic [7:0]           sum_next;
	logic                 result_fire;
	atfp_pkg::digit_chk_t chk;
	atfp_pkg::result_t    result;

	assign rx_byte  = s_tdata;
	assign sum_next = sum_q + rx_byte;

	// Hold off a checksum byte while the result slot is still full
	assign s_tready = !(out_valid_q && (phase_q == atfp_pkg::PH_SUM));
	assign accept   = s_tvalid && s_tready;

	assign result_fire = accept && (phase_q == atfp_pkg::PH_SUM) && (rx_byte == sum_q);

	atfp_digit_check u_digit_check (
		.field_pos (field_pos_q),
		.rx_byte   (rx_byte),
		.chk       (chk)
	);

	// Write the header registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_hdr_q  <= 8'h00;
			second_hdr_q <= 8'h00;
		end else if (cfg_we) begin
			case (cfg_index)
				atfp_pkg::CFG_FIRST_HEADER:  first_hdr_q  <= cfg_data;
				atfp_pkg::CFG_SECOND_HEADER: second_hdr_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Advance the frame parser on each accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= atfp_pkg::PH_HUNT1;
			field_pos_q <= 4'd0;
			sum_q       <= 8'h00;
		end else if (accept) begin
			case (phase_q)
				atfp_pkg::PH_HUNT1: begin
					if (rx_byte == first_hdr_q) begin
						field_pos_q <= 4'd0;
						sum_q       <= rx_byte;
						phase_q     <= atfp_pkg::PH_HUNT2;
					end
				end
				atfp_pkg::PH_HUNT2: begin
					if (rx_byte == second_hdr_q) begin
						field_pos_q <= 4'd0;
						sum_q       <= sum_next;
						phase_q     <= atfp_pkg::PH_DATA;
					end else if (rx_byte == first_hdr_q) begin
						field_pos_q <= 4'd0;
						sum_q       <= rx_byte;
					end else begin
						phase_q <= atfp_pkg::PH_HUNT1;
					end
				end
				atfp_pkg::PH_DATA: begin
					if (field_pos_q == 4'd0) begin
						if (rx_byte == atfp_pkg::TYPE_A || rx_byte == atfp_pkg::TYPE_G) begin
							sum_q       <= sum_next;
							field_pos_q <= 4'd1;
						end else begin
							phase_q <= atfp_pkg::PH_HUNT1;
						end
					end else if (!chk.ok) begin
						phase_q <= atfp_pkg::PH_HUNT1;
					end else begin
						sum_q <= sum_next;
						if (chk.last) begin
							phase_q <= atfp_pkg::PH_SUM;
						end else begin
							field_pos_q <= field_pos_q + 4'd1;
						end
					end
				end
				default: begin
					phase_q <= atfp_pkg::PH_HUNT1;
				end
			endcase
		end
	end

	// Store each good digit in its slot
	always_ff @(posedge clk) begin
		if (accept && (phase_q == atfp_pkg::PH_DATA) && (field_pos_q != 4'd0) && chk.ok) begin
			digit_q[chk.slot] <= chk.value;
		end
	end

	// Pack the stored digits into the result fields
	always_comb begin
		result.year_bcd      = {digit_q[0], digit_q[1], digit_q[2], digit_q[3]};
		result.month_bcd     = {digit_q[4][0], digit_q[5]};
		result.day_bcd       = {digit_q[6][1:0], digit_q[7]};
		result.weekday_digit = digit_q[8][2:0];
		result.hour_bcd      = {digit_q[9][1:0], digit_q[10]};
		result.minute_bcd    = {digit_q[11][2:0], digit_q[12]};
		result.second_bcd    = {digit_q[13][2:0], digit_q[14]};
	end

	// Hold the result until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (result_fire) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (result_fire) begin
			out_data_q <= result;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(atfp_pkg::RESULT_BYTES_BITS - atfp_pkg::RESULT_BITS){1'b0}}, out_data_q};

	// A checksum byte always ends the frame
	a_sum_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && (phase_q == atfp_pkg::PH_SUM)) |=> (phase_q == atfp_pkg::PH_HUNT1))
		else $error("checksum byte did not return the parser to the hunt");

	// The checksum phase is entered only after the last digit slot
	a_sum_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == atfp_pkg::PH_SUM) |-> (field_pos_q == 4'd15))
		else $error("checksum phase reached before the last digit");

	// Input is held off only for a checksum byte while a result waits
	a_stall_reason: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> (m_tvalid && (phase_q == atfp_pkg::PH_SUM)))
		else $error("input stalled without a pending result");

	// A new result never lands on one that was not taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		result_fire |-> !out_valid_q)
		else $error("result register overwritten");

endmodule

### rtl/atfp_digit_check.sv
// Range check and value extraction for one ASCII digit of the time frame.
module atfp_digit_check (
	input  logic [3:0]              field_pos,
	input  logic [7:0]              rx_byte,
	output atfp_pkg::digit_chk_t    chk
);

	logic [3:0] slot;

	// Map the field position (1..15) to a digit slot (0..14)
	assign slot = field_pos - 4'd1;

	// Accept bytes from '0' up to the slot limit
	always_comb begin
		chk.slot  = slot;
		chk.last  = (slot == atfp_pkg::LAST_DIGIT);
		chk.value = 4'(rx_byte - atfp_pkg::ASCII_ZERO);
		chk.ok    = (slot != 4'd15) && (rx_byte >= atfp_pkg::ASCII_ZERO)
			&& (rx_byte <= atfp_pkg::digit_limit(slot));
	end

endmodule

### dv/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the ASCII time frame parser with a cycle-free frame predictor.
module testbench;

	localparam int QUIET_LIMIT = 3000;
	localparam int PHASE_BYTES = 250;

	typedef struct {
		logic [7:0]          b;
		bit                  typed;
		atfp_pkg::result_t   res;
	} row_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [55:0] m_tdata;
	logic        cfg_we = 1'b0;
	logic        cfg_index = atfp_pkg::CFG_FIRST_HEADER;
	logic [7:0]  cfg_data = '0;

	// Side-band of the word on s_tdata: a hand-written time it must produce
	bit                 row_typed = 1'b0;
	atfp_pkg::result_t  row_result = '0;

	// Frame predictor state
	logic [1:0]  fr_phase = atfp_pkg::PH_HUNT1;
	logic [3:0]  fr_pos = '0;
	logic [7:0]  fr_sum = '0;
	logic [3:0]  fr_digits [15];
	logic [7:0]  hdr_first = '0;
	logic [7:0]  hdr_second = '0;

	atfp_pkg::result_t  pending_times [$];
	row_t        directed_rows [$];
	int          mismatch_count = 0;
	int          bytes_sent = 0;
	int          burst_left = 0;
	int          quiet_cycles = 0;
	int          rx_cycle = 0;
	int          stall_mode = 0;
	logic [7:0]  cur_first = '0;
	logic [7:0]  cur_second = '0;

	ascii_time_frame_parser uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Highest ASCII digit allowed at each digit slot
	function automatic logic [7:0] slot_ceiling(input int slot);
		case (slot)
			4:       return "1";
			6:       return "3";
			8:       return "6";
			9:       return "2";
			11, 13:  return "5";
			default: return "9";
		endcase
	endfunction

	// Advance the frame state by one byte; return 1 when a time word is due
	function automatic bit decode_time_byte(input logic [7:0] b,
			output atfp_pkg::result_t t);
		int slot;
		t = '0;
		case (fr_phase)
			atfp_pkg::PH_HUNT1: begin
				if (b == hdr_first) begin
					fr_pos = '0;
					fr_sum = b;
					fr_phase = atfp_pkg::PH_HUNT2;
				end
			end
			atfp_pkg::PH_HUNT2: begin
				if (b == hdr_second) begin
					fr_pos = '0;
					fr_sum = fr_sum + b;
					fr_phase = atfp_pkg::PH_DATA;
				end else if (b == hdr_first) begin
					fr_pos = '0;
					fr_sum = b;
				end else begin
					fr_phase = atfp_pkg::PH_HUNT1;
				end
			end
			atfp_pkg::PH_DATA: begin
				if (fr_pos == 0) begin
					if (b == atfp_pkg::TYPE_A || b == atfp_pkg::TYPE_G) begin
						fr_sum = fr_sum + b;
						fr_pos = 4'd1;
					end else begin
						fr_phase = atfp_pkg::PH_HUNT1;
					end
				end else begin
					slot = int'(fr_pos) - 1;
					if (b < atfp_pkg::ASCII_ZERO || b > slot_ceiling(slot)) begin
						fr_phase = atfp_pkg::PH_HUNT1;
					end else begin
						fr_digits[slot] = 4'(b - atfp_pkg::ASCII_ZERO);
						fr_sum = fr_sum + b;
						if (slot == atfp_pkg::DIGIT_COUNT - 1)
							fr_phase = atfp_pkg::PH_SUM;
						else
							fr_pos = fr_pos + 4'd1;
					end
				end
			end
			default: begin
				fr_phase = atfp_pkg::PH_HUNT1;
				if (b == fr_sum) begin
					t.year_bcd      = {fr_digits[0], fr_digits[1], fr_digits[2], fr_digits[3]};
					t.month_bcd     = {fr_digits[4][0], fr_digits[5]};
					t.day_bcd       = {fr_digits[6][1:0], fr_digits[7]};
					t.weekday_digit = fr_digits[8][2:0];
					t.hour_bcd      = {fr_digits[9][1:0], fr_digits[10]};
					t.minute_bcd    = {fr_digits[11][2:0], fr_digits[12]};
					t.second_bcd    = {fr_digits[13][2:0], fr_digits[14]};
					return 1'b1;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic check_field(input string label, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$display("%0t: %s expected %h actual %h", $time, label, want, got);
			mismatch_count++;
		end
	endtask

	// Check time words, track header writes, predict from accepted bytes
	always @(posedge clk) begin
		atfp_pkg::result_t want;
		atfp_pkg::result_t got;
		atfp_pkg::result_t pred;
		bit                hit;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				got = atfp_pkg::result_t'(m_tdata[49:0]);
				if (pending_times.size() == 0) begin
					$display("%0t: time word with none expected, actual %h", $time, m_tdata);
					mismatch_count++;
				end else begin
					want = pending_times.pop_front();
					check_field("year_bcd", want.year_bcd, got.year_bcd);
					check_field("month_bcd", 16'(want.month_bcd), 16'(got.month_bcd));
					check_field("day_bcd", 16'(want.day_bcd), 16'(got.day_bcd));
					check_field("weekday_digit", 16'(want.weekday_digit),
						16'(got.weekday_digit));
					check_field("hour_bcd", 16'(want.hour_bcd), 16'(got.hour_bcd));
					check_field("minute_bcd", 16'(want.minute_bcd), 16'(got.minute_bcd));
					check_field("second_bcd", 16'(want.second_bcd), 16'(got.second_bcd));
					check_field("zero fill", 16'h0, 16'(m_tdata[55:50]));
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					atfp_pkg::CFG_FIRST_HEADER:  hdr_first = cfg_data;
					atfp_pkg::CFG_SECOND_HEADER: hdr_second = cfg_data;
					default: ;
				endcase
			end
			if (s_tvalid && s_tready) begin
				hit = decode_time_byte(s_tdata, pred);
				if (row_typed)
					pending_times.push_back(row_result);
				else if (hit)
					pending_times.push_back(pred);
			end
		end
	end

	// Stall the result side: always ready, coin flips, or long holds
	always @(posedge clk) begin
		rx_cycle++;
		if (rx_cycle % 64 == 0)
			stall_mode = $urandom_range(0, 2);
		case (stall_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= $urandom_range(0, 1);
			default: m_tready <= (rx_cycle % 16) >= 12;
		endcase
	end

	// End the run when no word moves on either side for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
				$display("testbench failed");
				$finish;
			end
		end
	end

	function automatic void add_row(input logic [7:0] b, input bit typed = 1'b0,
			input atfp_pkg::result_t res = '0);
		row_t r;
		r.b = b;
		r.typed = typed;
		r.res = res;
		directed_rows.push_back(r);
	endfunction

	// Offer one byte, idling between bursts, and hold it until taken
	task automatic push_byte(input logic [7:0] b, input bit typed = 1'b0,
			input atfp_pkg::result_t res = '0);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 6);
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 24);
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= b;
		row_typed <= typed;
		row_result <= res;
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		burst_left--;
		bytes_sent++;
	endtask

	// Send a well-formed frame with random content, now and then broken
	task automatic send_frame();
		logic [7:0] chk;
		logic [7:0] ty;
		logic [7:0] lim;
		logic [7:0] d;
		int extra;
		extra = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : 0;
		repeat (extra) push_byte(cur_first);
		push_byte(cur_first);
		push_byte(cur_second);
		ty = $urandom_range(0, 1) ? atfp_pkg::TYPE_A : atfp_pkg::TYPE_G;
		if ($urandom_range(0, 15) == 0)
			ty = 8'($urandom_range(0, 255));
		chk = cur_first + cur_second + ty;
		push_byte(ty);
		for (int i = 0; i < atfp_pkg::DIGIT_COUNT; i++) begin
			lim = slot_ceiling(i);
			case ($urandom_range(0, 7))
				0:       d = atfp_pkg::ASCII_ZERO;
				1:       d = lim;
				default: d = 8'($urandom_range(atfp_pkg::ASCII_ZERO, lim));
			endcase
			if ($urandom_range(0, 59) == 0) begin
				case ($urandom_range(0, 2))
					0:       d = 8'($urandom_range(0, atfp_pkg::ASCII_ZERO - 8'd1));
					1:       d = lim + 8'd1;
					default: d = 8'($urandom_range(0, 255));
				endcase
			end
			chk = chk + d;
			push_byte(d);
		end
		if ($urandom_range(0, 6) == 0)
			chk = chk + 8'($urandom_range(1, 255));
		push_byte(chk);
	endtask

	// Drop valid and wait until every time word is out and the parser is quiet
	task automatic settle();
		s_tvalid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_times.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_headers(input logic [7:0] h1, input logic [7:0] h2);
		cfg_we <= 1'b1;
		cfg_index <= atfp_pkg::CFG_FIRST_HEADER;
		cfg_data <= h1;
		@(posedge clk);
		cfg_index <= atfp_pkg::CFG_SECOND_HEADER;
		cfg_data <= h2;
		@(posedge clk);
		cfg_we <= 1'b0;
		cur_first = h1;
		cur_second = h2;
	endtask

	initial begin
		string              max_digits;
		logic [7:0]         chk;
		atfp_pkg::result_t  top_time;
		logic [15:0]        header_plan [$];
		int                 target;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		write_headers(8'hAA, 8'h55);

		// Directed: wrong second header, bad type, repeated first header,
		// then a type G frame with every digit at its ceiling
		max_digits = "999919396295959";
		top_time = '0;
		top_time.year_bcd = 16'h9999;
		top_time.month_bcd = 5'h19;
		top_time.day_bcd = 6'h39;
		top_time.weekday_digit = 3'd6;
		top_time.hour_bcd = 6'h29;
		top_time.minute_bcd = 7'h59;
		top_time.second_bcd = 7'h59;
		add_row(8'hAA);
		add_row(8'h13);
		add_row(8'hAA);
		add_row(8'h55);
		add_row("X");
		add_row(8'hAA);
		add_row(8'hAA);
		add_row(8'h55);
		add_row(atfp_pkg::TYPE_G);
		chk = 8'hAA + 8'h55 + atfp_pkg::TYPE_G;
		for (int i = 0; i < atfp_pkg::DIGIT_COUNT; i++) begin
			add_row(max_digits[i]);
			chk = chk + max_digits[i];
		end
		add_row(chk, 1'b1, top_time);
		foreach (directed_rows[k])
			push_byte(directed_rows[k].b, directed_rows[k].typed, directed_rows[k].res);
		settle();

		// Random phases over header extremes, equal headers and random pairs
		header_plan = '{16'h00FF, 16'hFF00, 16'h7E7E, 16'h0000, 16'hFFFF,
			16'h0, 16'h0, 16'h0};
		for (int p = 5; p < 8; p++)
			header_plan[p] = 16'($urandom_range(0, 16'hFFFF));
		foreach (header_plan[p]) begin
			write_headers(header_plan[p][15:8], header_plan[p][7:0]);
			target = bytes_sent + PHASE_BYTES;
			while (bytes_sent < target) begin
				if ($urandom_range(0, 3) != 0) begin
					send_frame();
				end else begin
					repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
				end
			end
			settle();
		end

		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("testbench passed");
		else
			$display("testbench failed");
		$finish;
	end

endmodule
